### rtl/hte_pkg.sv
// Shared types and constants for the table-driven encoder and byte packer.
package hte_pkg;

    localparam int SYMBOL_COUNT = 128;
    localparam int SYM_W        = $clog2(SYMBOL_COUNT);
    localparam int MAX_CODE_LEN = 24;
    localparam int CODE_W       = 24;
    localparam int LEN_W        = 5;
    localparam int CMD_W        = 2;
    localparam int CNT_W        = 3;
    localparam int PEND_W       = 7;
    localparam int OBUF_W       = 24;
    localparam int NB_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    // Bytes produced by one transaction, first byte in the top eight bits.
    typedef struct packed {
        logic [NB_W-1:0]   nbytes;
        logic [OBUF_W-1:0] bytes;
    } t_pack_res;

endpackage

### rtl/huffman_table_encoder_packer.sv
// An encode or flush passes through the table read register and input stage, then the
// three-byte output buffer, which presents its bytes; a busy buffer stalls the input.
// One transaction per cycle while each yields at most one byte and no output stall;
// a transaction with more bytes holds the single output port until its last is taken.
// Reset clears the bit accumulator and all valid flags; the code table is not cleared.
module huffman_table_encoder_packer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hte_pkg::CMD_W-1:0]    i_command,
    input  logic [hte_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hte_pkg::CODE_W-1:0]   i_code_bits,
    input  logic [hte_pkg::LEN_W-1:0]    i_code_length,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last_byte
);
    import hte_pkg::*;

    logic             r_s1_valid;
    logic [CMD_W-1:0] r_s1_cmd;
    logic             w_accept;
    logic             w_fire;
    logic             w_take;
    logic             w_free;
    t_entry           w_entry;
    t_pack_res        w_res;

    assign w_take   = o_valid && !i_stall;
    assign w_fire   = r_s1_valid && w_free;
    assign o_stall  = r_s1_valid && !w_fire;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd <= i_command;
        end
    end

    hte_table u_table (
        .i_clk         (i_clk),
        .i_accept      (w_accept),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_entry       (w_entry)
    );

    hte_packer u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_command (r_s1_cmd),
        .i_entry   (w_entry),
        .o_res     (w_res)
    );

    hte_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .i_take  (w_take),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_last_byte)
    );

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_fire) |=> (r_s1_valid && $stable(r_s1_cmd)))
        else $error("waiting transaction dropped from the input stage");

endmodule

### rtl/hte_table.sv
// Code table memory with registered read port.
module hte_table (
    input  logic                       i_clk,
    input  logic                       i_accept,
    input  logic [hte_pkg::CMD_W-1:0]  i_command,
    input  logic [hte_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hte_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hte_pkg::LEN_W-1:0]  i_code_length,
    output hte_pkg::t_entry            o_entry
);
    import hte_pkg::*;

    t_entry           r_mem [SYMBOL_COUNT];
    t_entry           r_entry;
    t_entry           n_wr_entry;
    logic             w_in_range;
    logic             w_wr_en;

    always_comb begin
        w_in_range       = {1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
        w_wr_en          = i_accept && (t_cmd'(i_command) == CMD_LOAD) && w_in_range;
        n_wr_entry.code  = i_code_bits;
        if (i_code_length > LEN_W'(MAX_CODE_LEN)) begin
            n_wr_entry.len = LEN_W'(MAX_CODE_LEN);
        end else begin
            n_wr_entry.len = i_code_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_symbol] <= n_wr_entry;
        end
    end

    // Read only on accept so the entry holds while the transaction waits.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_entry <= r_mem[i_symbol];
        end
    end

    assign o_entry = r_entry;

endmodule

### rtl/hte_packer.sv
// Bit accumulator: merges a code with the pending bits and cuts whole bytes.
module hte_packer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [hte_pkg::CMD_W-1:0] i_command,
    input  hte_pkg::t_entry           i_entry,
    output hte_pkg::t_pack_res        o_res
);
    import hte_pkg::*;

    logic [PEND_W-1:0] r_pb;
    logic [CNT_W-1:0]  r_cnt;
    logic [PEND_W-1:0] n_pb;
    logic [CNT_W-1:0]  n_cnt;

    logic [LEN_W-1:0]  w_len;
    logic [CODE_W-1:0] w_mask;
    logic [CODE_W-1:0] w_masked;
    logic [CODE_W-1:0] w_rev;
    logic [PEND_W-1:0] w_pb_al;
    logic [31:0]       w_word;
    logic [31:0]       w_rest;
    logic [5:0]        w_total;
    logic [NB_W-1:0]   w_nb;
    logic [CNT_W-1:0]  w_cnt_enc;
    t_pack_res         w_res;

    always_comb begin
        if (i_entry.len > LEN_W'(MAX_CODE_LEN)) begin
            w_len = LEN_W'(MAX_CODE_LEN);
        end else begin
            w_len = i_entry.len;
        end
        // A full-length code wraps the shift to zero and the mask to all ones.
        w_mask   = (CODE_W'(1) << w_len) - CODE_W'(1);
        w_masked = i_entry.code & w_mask;
        for (int i = 0; i < CODE_W; i++) begin
            w_rev[CODE_W-1-i] = w_masked[i];
        end

        // Earliest pending bit goes to bit 31, the code follows right after it.
        w_pb_al   = r_pb << (CNT_W'(PEND_W) - r_cnt);
        w_word    = {w_pb_al, 25'b0} | ({w_rev, 8'b0} >> r_cnt);
        w_total   = {3'b0, r_cnt} + {1'b0, w_len};
        w_nb      = w_total[4:3];
        w_cnt_enc = w_total[2:0];
        w_rest    = w_word << {w_nb, 3'b0};

        n_pb         = r_pb;
        n_cnt        = r_cnt;
        w_res.bytes  = w_word[31:8];
        w_res.nbytes = '0;
        case (t_cmd'(i_command))
            CMD_ENCODE: begin
                w_res.nbytes = w_nb;
                n_cnt        = w_cnt_enc;
                n_pb         = w_rest[31:25] >> (CNT_W'(PEND_W) - w_cnt_enc);
            end
            CMD_FLUSH: begin
                // The pending bits sit at the top of the word, zero padded below.
                w_res.bytes = {w_pb_al, 1'b0, 16'b0};
                if (r_cnt != '0) begin
                    w_res.nbytes = NB_W'(1);
                end
                n_cnt = '0;
                n_pb  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb  <= '0;
            r_cnt <= '0;
        end else if (i_fire) begin
            r_pb  <= n_pb;
            r_cnt <= n_cnt;
        end
    end

    assign o_res = w_res;

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (t_cmd'(i_command) == CMD_FLUSH)) |=> (r_cnt == '0))
        else $error("pending count not cleared by flush");

    a_load_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (t_cmd'(i_command) == CMD_LOAD)) |=> ($stable(r_cnt) && $stable(r_pb)))
        else $error("table load disturbed the bit accumulator");

endmodule

### rtl/hte_out_buf.sv
// Output buffer that holds up to three bytes of one transaction and hands them out one at a time.
module hte_out_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  hte_pkg::t_pack_res          i_res,
    input  logic                        i_take,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [7:0]                  o_byte,
    output logic                        o_last
);
    import hte_pkg::*;

    logic [OBUF_W-1:0] r_buf;
    logic [NB_W-1:0]   r_left;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res.bytes;
        end else if (i_take) begin
            r_buf <= r_buf << 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_res.nbytes;
        end else if (i_take) begin
            r_left <= r_left - NB_W'(1);
        end
    end

    assign o_valid = (r_left != '0);
    assign o_byte  = r_buf[OBUF_W-1 -: 8];
    assign o_last  = (r_left == NB_W'(1));
    assign o_free  = (r_left == '0) || ((r_left == NB_W'(1)) && i_take);

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("output buffer loaded while bytes were still waiting");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_load) |=> (r_left == $past(r_left) - NB_W'(1)))
        else $error("byte count did not step down on a taken byte");

endmodule
